// File: rtl/mgcb_pkg.sv
// Shared types and constants for the margin gradient canvas blend unit.
// No dependencies; imported by every module of the block.
package mgcb_pkg;

    localparam int CoordW    = 16;            // pixel coordinate and screen size
    localparam int SizeW     = 12;            // margin and gradient widths
    localparam int PixW      = 32;            // ARGB8888 / xRGB8888
    localparam int ChanW     = 8;             // one colour channel
    localparam int NumChan   = 3;             // R, G, B
    localparam int DistW     = SizeW;         // ring distances never exceed the gradient
    localparam int SqW       = 2 * DistW + 1; // dx*dx + dy*dy
    localparam int RootW     = DistW + 1;     // floor sqrt of the above
    localparam int SqStages  = (SqW + 1) / 2; // one root bit per stage
    localparam int DivStages = ChanW;         // one quotient bit per stage
    localparam int CfgAddrW  = 3;

    typedef enum logic [CfgAddrW-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_MARGIN_SIZE   = 3'd2,
        REG_GRADIENT_SIZE = 3'd3,
        REG_BASE_COLOUR   = 3'd4,
        REG_BACKDROP      = 3'd5
    } cfg_reg_t;

    // Pixel class; ring classes are resolved to blend or pass before the blend stage
    typedef enum logic [2:0] {
        CLS_BASE,
        CLS_BLEND,
        CLS_PASS,
        CLS_EDGE,
        CLS_CORNER
    } cls_t;

    typedef struct packed {
        cls_t              cls;
        logic [DistW-1:0]  dx;     // edge distance, or x distance at a corner
        logic [DistW-1:0]  dy;
        logic [PixW-1:0]   px;
        logic [SizeW-1:0]  rem;    // alpha step divider remainder
        logic [ChanW-1:0]  step;   // alpha step quotient
        logic [ChanW-1:0]  alpha;
    } side_t;

    typedef struct packed {
        cls_t              cls;
        logic [ChanW-1:0]  alpha;
        logic [PixW-1:0]   px;
    } blend_req_t;

endpackage

// File: rtl/mgcb_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
// Depends on mgcb_pkg for widths and stage count.
module mgcb_isqrt (
    input  logic                        aclk,
    input  logic                        ce,
    input  logic [mgcb_pkg::SqW-1:0]    radicand,
    output logic [mgcb_pkg::RootW-1:0]  root
);
    import mgcb_pkg::*;

    logic [SqW-1:0] v_reg  [SqStages];
    logic [SqW-1:0] r_reg  [SqStages];
    logic [SqW-1:0] v_next [SqStages];
    logic [SqW-1:0] r_next [SqStages];
    logic [SqW-1:0] v_in   [SqStages];
    logic [SqW-1:0] r_in   [SqStages];
    logic [SqW-1:0] bit_w  [SqStages];
    logic [SqW-1:0] trial  [SqStages];

    always_comb begin
        for (int i = 0; i < SqStages; i++) begin
            v_in[i]  = (i == 0) ? radicand : v_reg[(i == 0) ? 0 : i - 1];
            r_in[i]  = (i == 0) ? '0 : r_reg[(i == 0) ? 0 : i - 1];
            bit_w[i] = SqW'(1) << (2 * (SqStages - 1 - i));
            trial[i] = r_in[i] + bit_w[i];
            if (v_in[i] >= trial[i]) begin
                v_next[i] = v_in[i] - trial[i];
                r_next[i] = (r_in[i] >> 1) + bit_w[i];
            end else begin
                v_next[i] = v_in[i];
                r_next[i] = r_in[i] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < SqStages; i++) begin
                v_reg[i] <= v_next[i];
                r_reg[i] <= r_next[i];
            end
        end
    end

    assign root = r_reg[SqStages-1][RootW-1:0];

endmodule

// File: rtl/mgcb_blend.sv
// Two-stage per-channel alpha blend and final pixel selection.
// Depends on mgcb_pkg for blend_req_t and widths.
module mgcb_blend (
    input  logic                       aclk,
    input  logic                       ce,
    input  mgcb_pkg::blend_req_t       req,
    input  logic [mgcb_pkg::PixW-1:0]  base_colour,
    output logic [mgcb_pkg::PixW-1:0]  pixel
);
    import mgcb_pkg::*;

    localparam int PcW = 2 * ChanW;     // (255-a)*c
    localparam int PpW = 2 * ChanW + 1; // (a+1)*p

    logic [ChanW-1:0]   wc;
    logic [ChanW:0]     wp;
    logic [PcW-1:0]     pc_reg [NumChan];
    logic [PpW-1:0]     pp_reg [NumChan];
    blend_req_t         req_reg;
    logic [PpW-1:0]     sum    [NumChan];
    logic [PixW-1:0]    mixed;
    logic [PixW-1:0]    pixel_next;
    logic [PixW-1:0]    pixel_reg;

    assign wc = ~req.alpha;
    assign wp = {1'b0, req.alpha} + 1'b1;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int c = 0; c < NumChan; c++) begin
                pc_reg[c] <= wc * base_colour[c*ChanW +: ChanW];
                pp_reg[c] <= wp * req.px[c*ChanW +: ChanW];
            end
            req_reg <= req;
        end
    end

    always_comb begin
        mixed = '0;
        for (int c = 0; c < NumChan; c++) begin
            sum[c] = {1'b0, pc_reg[c]} + pp_reg[c];
            mixed[c*ChanW +: ChanW] = sum[c][ChanW +: ChanW];
        end
        unique case (req_reg.cls)
            CLS_BASE: pixel_next = base_colour;
            CLS_PASS: pixel_next = req_reg.px;
            default:  pixel_next = mixed;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

// File: rtl/margin_gradient_canvas_blend_unit.sv
// Top level of the margin gradient canvas blend unit.
// Depends on mgcb_pkg, mgcb_isqrt and mgcb_blend.
//
// Usage:
//   Input channel s_* carries one pixel transaction: coordinate and backdrop pixel.
//   Output channel m_* returns the canvas pixel, one per input, in order.
//   Both channels are valid/ready. The cfg_* port writes one register per cycle
//   at cfg_wr_en (index 0..5: width, height, margin, gradient, base colour,
//   backdrop present); write only while no transaction is in flight.
// Throughput and depth:
//   Throughput is one pixel per cycle while m_ready does not stall the output. The
//   depth is set by the 13-stage corner square root pipeline plus classification,
//   squaring, alpha and blend stages.
// Stall:
//   The whole pipeline advances together; when m_valid is high and m_ready is
//   low every stage holds and s_ready drops, so nothing is lost or repeated.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline and loads the
//   register defaults (1024 x 768, margin 64, gradient 4, base 0, no backdrop).
module margin_gradient_canvas_blend_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mgcb_pkg::CoordW-1:0]    s_pixel_x,
    input  logic [mgcb_pkg::CoordW-1:0]    s_pixel_y,
    input  logic [mgcb_pkg::PixW-1:0]      s_backdrop_pixel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mgcb_pkg::PixW-1:0]      m_canvas_pixel,
    input  logic                           cfg_wr_en,
    input  logic [mgcb_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [mgcb_pkg::PixW-1:0]      cfg_wdata
);
    import mgcb_pkg::*;

    localparam int SW        = CoordW + 2;
    localparam int DivFirst  = 3;
    localparam int DivLast   = DivFirst + DivStages - 1;
    localparam int RootIdx   = 2 + SqStages;
    localparam int SelIdx    = RootIdx + 1;
    localparam int TopStages = SelIdx + 1;
    localparam int Latency   = TopStages + 2;
    localparam int ProdW     = ChanW + RootW;
    localparam int ChkW      = ChanW + SizeW + 1;

    localparam logic [CoordW-1:0] RstWidth  = 16'd1024;
    localparam logic [CoordW-1:0] RstHeight = 16'd768;
    localparam logic [SizeW-1:0]  RstMargin = 12'd64;
    localparam logic [SizeW-1:0]  RstGrad   = 12'd4;

    // configuration registers
    logic [CoordW-1:0] width_reg;
    logic [CoordW-1:0] height_reg;
    logic [SizeW-1:0]  margin_reg;
    logic [SizeW-1:0]  grad_reg;
    logic [PixW-1:0]   base_reg;
    logic              present_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= RstWidth;
            height_reg  <= RstHeight;
            margin_reg  <= RstMargin;
            grad_reg    <= RstGrad;
            base_reg    <= '0;
            present_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SCREEN_WIDTH:  width_reg   <= cfg_wdata[CoordW-1:0];
                REG_SCREEN_HEIGHT: height_reg  <= cfg_wdata[CoordW-1:0];
                REG_MARGIN_SIZE:   margin_reg  <= cfg_wdata[SizeW-1:0];
                REG_GRADIENT_SIZE: grad_reg    <= cfg_wdata[SizeW-1:0];
                REG_BASE_COLOUR:   base_reg    <= cfg_wdata;
                REG_BACKDROP:      present_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [SizeW-1:0] g_eff;
    logic [ChanW-1:0] alpha_base;
    logic [ChanW-1:0] num;

    assign g_eff      = (grad_reg > margin_reg) ? margin_reg : grad_reg;
    assign alpha_base = base_reg[PixW-1 -: ChanW];
    assign num        = ~alpha_base;

    // pipeline control
    logic [Latency-1:0] vld_reg;
    logic               ce;

    assign ce      = !vld_reg[Latency-1] || m_ready;
    assign s_ready = ce;
    assign m_valid = vld_reg[Latency-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[Latency-2:0], s_valid};
        end
    end

    // classification
    logic signed [SW-1:0] x_s, y_s, m_s, k_s, wm_s, hm_s, wk_s, hk_s, dx_s, dy_s;
    logic                 xin, yin, outer;
    cls_t                 cls_in;
    logic [DistW-1:0]     d_first;

    always_comb begin
        x_s   = signed'({2'b00, s_pixel_x});
        y_s   = signed'({2'b00, s_pixel_y});
        m_s   = signed'({{(SW-SizeW){1'b0}}, margin_reg});
        k_s   = signed'({{(SW-SizeW){1'b0}}, margin_reg - g_eff});
        wm_s  = signed'({2'b00, width_reg}) - m_s;
        hm_s  = signed'({2'b00, height_reg}) - m_s;
        wk_s  = signed'({2'b00, width_reg}) - k_s;
        hk_s  = signed'({2'b00, height_reg}) - k_s;
        xin   = (x_s >= m_s) && (x_s < wm_s);
        yin   = (y_s >= m_s) && (y_s < hm_s);
        outer = (x_s < k_s) || (x_s >= wk_s) || (y_s < k_s) || (y_s >= hk_s);
        dx_s  = (x_s < m_s) ? (m_s - x_s) : (x_s - wm_s);
        dy_s  = (y_s < m_s) ? (m_s - y_s) : (y_s - hm_s);
        d_first = dx_s[DistW-1:0];
        if (!present_reg) begin
            cls_in = CLS_BASE;
        end else if (xin && yin) begin
            cls_in = CLS_BLEND;
        end else if (outer) begin
            cls_in = CLS_PASS;
        end else if (xin) begin
            cls_in  = CLS_EDGE;
            d_first = dy_s[DistW-1:0];
        end else if (yin) begin
            cls_in = CLS_EDGE;
        end else begin
            cls_in = CLS_CORNER;
        end
    end

    // side channel, divider and alpha stages
    side_t              side_reg  [TopStages];
    side_t              side_next [TopStages];
    logic [2*DistW-1:0] sq_x_reg, sq_y_reg;
    logic [SqW-1:0]     sum_reg;
    logic [RootW-1:0]   root;

    always_comb begin
        logic [SizeW:0]   rem_t;
        logic [RootW-1:0] d;
        logic [ProdW-1:0] prod;
        logic             far;
        rem_t = '0;
        d     = '0;
        prod  = '0;
        far   = 1'b0;
        side_next[0].cls   = cls_in;
        side_next[0].dx    = d_first;
        side_next[0].dy    = dy_s[DistW-1:0];
        side_next[0].px    = s_backdrop_pixel;
        side_next[0].rem   = '0;
        side_next[0].step  = '0;
        side_next[0].alpha = '0;
        for (int j = 1; j < TopStages; j++) begin
            side_next[j] = side_reg[j-1];
            if (j >= DivFirst && j <= DivLast) begin
                rem_t = {side_reg[j-1].rem, num[(DivLast - j) % ChanW]};
                if (rem_t >= {1'b0, g_eff}) begin
                    side_next[j].rem = SizeW'(rem_t - {1'b0, g_eff});
                    side_next[j].step[(DivLast - j) % ChanW] = 1'b1;
                end else begin
                    side_next[j].rem = rem_t[SizeW-1:0];
                end
            end
            if (j == SelIdx) begin
                d    = (side_reg[j-1].cls == CLS_CORNER) ? root
                                                         : {1'b0, side_reg[j-1].dx};
                prod = side_reg[j-1].step * d;
                far  = (g_eff == '0) || (d > {1'b0, g_eff});
                if (side_reg[j-1].cls == CLS_EDGE || side_reg[j-1].cls == CLS_CORNER) begin
                    side_next[j].cls   = far ? CLS_PASS : CLS_BLEND;
                    side_next[j].alpha = alpha_base + prod[ChanW-1:0];
                end else begin
                    side_next[j].alpha = alpha_base;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int j = 0; j < TopStages; j++) begin
                side_reg[j] <= side_next[j];
            end
            sq_x_reg <= side_reg[0].dx * side_reg[0].dx;
            sq_y_reg <= side_reg[0].dy * side_reg[0].dy;
            sum_reg  <= {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
        end
    end

    mgcb_isqrt u_isqrt (
        .aclk     (aclk),
        .ce       (ce),
        .radicand (sum_reg),
        .root     (root)
    );

    blend_req_t blend_req;

    assign blend_req.cls   = side_reg[SelIdx].cls;
    assign blend_req.alpha = side_reg[SelIdx].alpha;
    assign blend_req.px    = side_reg[SelIdx].px;

    mgcb_blend u_blend (
        .aclk        (aclk),
        .ce          (ce),
        .req         (blend_req),
        .base_colour (base_reg),
        .pixel       (m_canvas_pixel)
    );

    // checks
    a_div_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[DivLast] && g_eff != '0) |->
            (side_reg[DivLast].rem < g_eff) &&
            ((ChkW'(side_reg[DivLast].step) * ChkW'(g_eff) + ChkW'(side_reg[DivLast].rem))
                == ChkW'(num)))
        else $error("alpha step divider result inconsistent");

    a_ring_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[0] && (side_reg[0].cls == CLS_EDGE || side_reg[0].cls == CLS_CORNER)) |->
            (side_reg[0].dx <= g_eff) &&
            (side_reg[0].cls != CLS_CORNER || side_reg[0].dy <= g_eff))
        else $error("gradient ring distance beyond gradient width");

    a_sel_resolved: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[SelIdx] |->
            (side_reg[SelIdx].cls == CLS_BASE || side_reg[SelIdx].cls == CLS_BLEND ||
             side_reg[SelIdx].cls == CLS_PASS))
        else $error("ring class reached blend stage unresolved");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (vld_reg == '0))
        else $error("pipeline not empty after reset");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for margin_gradient_canvas_blend_unit: directed rows, then random pixels
// over a series of register settings, each result checked against a typed-in expectation or a canvas pixel predictor.
// Depends on mgcb_pkg and the RTL of the block only.
module tb_top;
    import mgcb_pkg::*;

    localparam int NumPhases  = 10;
    localparam int PhaseItems = 90;
    localparam int HoldCycles = 200;
    localparam int TailCycles = 24;

    typedef struct {
        bit               is_cfg;
        cfg_reg_t         addr;
        logic [PixW-1:0]  value;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [PixW-1:0]  backdrop;
        bit               has_want;
        logic [PixW-1:0]  want;
    } row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [CoordW-1:0]    s_pixel_x;
    logic [CoordW-1:0]    s_pixel_y;
    logic [PixW-1:0]      s_backdrop_pixel;
    logic                 m_valid;
    logic                 m_ready;
    logic [PixW-1:0]      m_canvas_pixel;
    logic                 cfg_wr_en;
    logic [CfgAddrW-1:0]  cfg_addr;
    logic [PixW-1:0]      cfg_wdata;

    // typed-in expectation travelling with the payload
    logic                 typed_valid;
    logic [PixW-1:0]      typed_canvas;

    logic [CoordW-1:0]    cur_width;
    logic [CoordW-1:0]    cur_height;
    logic [SizeW-1:0]     cur_margin;
    logic [SizeW-1:0]     cur_gradient;
    logic [PixW-1:0]      cur_base;
    logic                 cur_backdrop;

    logic [PixW-1:0]      pending_canvas[$];
    row_t                 rows[$];
    bit                   tx_idle_en;
    bit                   rx_idle_en;
    bit                   hold_req;
    int                   pixels_sent;
    int                   canvas_checked;
    int                   settings_used;
    int                   errors;

    margin_gradient_canvas_blend_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pixel_x        (s_pixel_x),
        .s_pixel_y        (s_pixel_y),
        .s_backdrop_pixel (s_backdrop_pixel),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_canvas_pixel   (m_canvas_pixel),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [PixW-1:0] blend_rgb(logic [PixW-1:0] colour, int unsigned alpha,
                                                  logic [PixW-1:0] backdrop);
        logic [PixW-1:0] res;
        int unsigned     c;
        int unsigned     p;
        res = '0;
        for (int ch = 0; ch < NumChan; ch++) begin
            c = 32'(colour[ch*ChanW +: ChanW]);
            p = 32'(backdrop[ch*ChanW +: ChanW]);
            res[ch*ChanW +: ChanW] = ChanW'(((255 - alpha) * c + (alpha + 1) * p) / 256);
        end
        return res;
    endfunction

    function automatic longint floor_root(longint v);
        longint r;
        longint t;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [PixW-1:0] predict_canvas(logic [CoordW-1:0] px_x,
                                                       logic [CoordW-1:0] px_y,
                                                       logic [PixW-1:0] backdrop);
        longint      x, y, w, h, m, g, k, dx, dy, d;
        int unsigned a;
        int unsigned alpha_step;
        int unsigned ring_alpha;
        bit          xin;
        bit          yin;
        x = longint'(px_x);
        y = longint'(px_y);
        w = longint'(cur_width);
        h = longint'(cur_height);
        m = longint'(cur_margin);
        g = longint'((cur_gradient > cur_margin) ? cur_margin : cur_gradient);
        k = m - g;
        a = 32'(cur_base[31:24]);
        xin = x >= m && x < w - m;
        yin = y >= m && y < h - m;
        if (!cur_backdrop)
            return cur_base;
        if (xin && yin)
            return blend_rgb(cur_base, a, backdrop);
        if (x < k || x >= w - k || y < k || y >= h - k)
            return backdrop;
        dx = (x < m) ? m - x : x - (w - m);
        dy = (y < m) ? m - y : y - (h - m);
        if (xin)
            d = dy;
        else if (yin)
            d = dx;
        else
            d = floor_root(dx * dx + dy * dy);
        if (g == 0 || d > g)
            return backdrop;
        alpha_step = (255 - a) / int'(g);
        ring_alpha = (a + alpha_step * int'(d)) & 8'hff;
        return blend_rgb(cur_base, ring_alpha, backdrop);
    endfunction

    always @(posedge aclk) begin
        logic [PixW-1:0] want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_canvas.push_back(typed_valid ? typed_canvas
                    : predict_canvas(s_pixel_x, s_pixel_y, s_backdrop_pixel));
                pixels_sent++;
            end
            if (m_valid && m_ready) begin
                if (pending_canvas.size() == 0) begin
                    errors++;
                    $display("%0t: canvas pixel %08h with no transaction outstanding",
                             $time, m_canvas_pixel);
                end else begin
                    want = pending_canvas.pop_front();
                    canvas_checked++;
                    if (m_canvas_pixel !== want) begin
                        errors++;
                        $display("%0t: canvas_pixel mismatch, expected %08h, got %08h",
                                 $time, want, m_canvas_pixel);
                    end
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready = 1'b0;
                repeat (HoldCycles) @(negedge aclk);
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                gap = $urandom_range(1, 19);
                repeat (gap) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
                @(negedge aclk);
            end
        end
    end

    task automatic offer_pixel(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                               logic [PixW-1:0] backdrop, bit has_want, logic [PixW-1:0] want);
        int gap;
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_pixel_x = x;
        s_pixel_y = y;
        s_backdrop_pixel = backdrop;
        typed_valid = has_want;
        typed_canvas = want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_canvas();
        s_valid = 1'b0;
        while (pending_canvas.size() != 0) @(negedge aclk);
        repeat (TailCycles) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [PixW-1:0] v);
        cfg_wr_en = 1'b1;
        cfg_addr = r;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (r)
            REG_SCREEN_WIDTH:  cur_width = v[CoordW-1:0];
            REG_SCREEN_HEIGHT: cur_height = v[CoordW-1:0];
            REG_MARGIN_SIZE:   cur_margin = v[SizeW-1:0];
            REG_GRADIENT_SIZE: cur_gradient = v[SizeW-1:0];
            REG_BASE_COLOUR:   cur_base = v;
            REG_BACKDROP:      cur_backdrop = v[0];
            default: ;
        endcase
    endtask

    task automatic add_cfg(cfg_reg_t r, logic [PixW-1:0] v);
        row_t row;
        row.is_cfg = 1'b1;
        row.addr = r;
        row.value = v;
        row.x = '0;
        row.y = '0;
        row.backdrop = '0;
        row.has_want = 1'b0;
        row.want = '0;
        rows.push_back(row);
    endtask

    task automatic add_pix(logic [CoordW-1:0] x, logic [CoordW-1:0] y, logic [PixW-1:0] backdrop,
                           bit has_want, logic [PixW-1:0] want);
        row_t row;
        row.is_cfg = 1'b0;
        row.addr = REG_SCREEN_WIDTH;
        row.value = '0;
        row.x = x;
        row.y = y;
        row.backdrop = backdrop;
        row.has_want = has_want;
        row.want = want;
        rows.push_back(row);
    endtask

    task automatic apply_setting(int unsigned w, int unsigned h, int unsigned m, int unsigned g,
                                 logic [PixW-1:0] base, bit bd);
        logic [PixW-1:0] junk;
        junk = $urandom;
        write_reg(REG_SCREEN_WIDTH, {junk[31:16], w[15:0]});
        write_reg(REG_SCREEN_HEIGHT, {junk[15:0], h[15:0]});
        write_reg(REG_MARGIN_SIZE, {junk[31:12], m[11:0]});
        write_reg(REG_GRADIENT_SIZE, {junk[19:0], g[11:0]});
        write_reg(REG_BASE_COLOUR, base);
        write_reg(REG_BACKDROP, {junk[31:1], bd});
        settings_used++;
    endtask

    // coordinates cluster on the ring edges and the inner box, with some spread over the full range
    function automatic logic [CoordW-1:0] pick_coord(logic [CoordW-1:0] span_size);
        longint m, g, k, v, span;
        int     sel;
        m = longint'(cur_margin);
        g = longint'((cur_gradient > cur_margin) ? cur_margin : cur_gradient);
        k = m - g;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            v = longint'($urandom_range(0, 65535));
        else if (sel <= 3)
            v = k - 2 + longint'($urandom_range(0, int'(g) + 4));
        else if (sel <= 6)
            v = longint'(span_size) - m - 2 + longint'($urandom_range(0, int'(g) + 4));
        else begin
            span = longint'(span_size) - 2 * m;
            if (span <= 0)
                span = 1;
            v = m + (longint'($urandom) % span);
        end
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[CoordW-1:0];
    endfunction

    initial begin
        int unsigned rm;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_pixel_x = '0;
        s_pixel_y = '0;
        s_backdrop_pixel = '0;
        typed_valid = 1'b0;
        typed_canvas = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_SCREEN_WIDTH;
        cfg_wdata = '0;
        cur_width = 16'd1024;
        cur_height = 16'd768;
        cur_margin = 12'd64;
        cur_gradient = 12'd4;
        cur_base = '0;
        cur_backdrop = 1'b0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        hold_req = 1'b0;
        pixels_sent = 0;
        canvas_checked = 0;
        settings_used = 1;
        errors = 0;

        // reset defaults: no backdrop, base colour zero
        add_pix(16'd0, 16'd0, 32'hffffffff, 1'b1, 32'h0);
        add_pix(16'hffff, 16'hffff, 32'hffffffff, 1'b1, 32'h0);
        add_pix(16'd512, 16'd384, 32'h12345678, 1'b1, 32'h0);
        // 64 x 48 screen, margin 10, gradient 4
        add_cfg(REG_SCREEN_WIDTH, 32'd64);
        add_cfg(REG_SCREEN_HEIGHT, 32'd48);
        add_cfg(REG_MARGIN_SIZE, 32'd10);
        add_cfg(REG_GRADIENT_SIZE, 32'd4);
        add_cfg(REG_BASE_COLOUR, 32'h80204060);
        add_cfg(REG_BACKDROP, 32'd1);
        add_pix(16'd20, 16'd20, 32'h00ff00ff, 1'b0, 32'h0);
        add_pix(16'd10, 16'd10, 32'hffffffff, 1'b0, 32'h0);
        add_pix(16'd53, 16'd37, 32'h00000000, 1'b0, 32'h0);
        add_pix(16'd0, 16'd0, 32'hdeadbeef, 1'b1, 32'hdeadbeef);
        add_pix(16'd5, 16'd20, 32'h13579bdf, 1'b1, 32'h13579bdf);
        add_pix(16'd58, 16'd20, 32'h2468ace0, 1'b1, 32'h2468ace0);
        add_pix(16'd6, 16'd20, 32'hffffffff, 1'b0, 32'h0);
        add_pix(16'd9, 16'd20, 32'hffffffff, 1'b0, 32'h0);
        add_pix(16'd20, 16'd41, 32'h7f7f7f7f, 1'b0, 32'h0);
        add_pix(16'd7, 16'd7, 32'hffffffff, 1'b0, 32'h0);
        add_pix(16'd6, 16'd6, 32'hffffffff, 1'b0, 32'h0);
        add_pix(16'hffff, 16'd0, 32'h55aa55aa, 1'b1, 32'h55aa55aa);
        add_pix(16'd100, 16'd100, 32'haa55aa55, 1'b1, 32'haa55aa55);
        // gradient wider than the margin
        add_cfg(REG_GRADIENT_SIZE, 32'd4095);
        add_pix(16'd3, 16'd20, 32'hffffffff, 1'b0, 32'h0);
        // zero gradient: ring is empty
        add_cfg(REG_GRADIENT_SIZE, 32'd0);
        add_pix(16'd9, 16'd20, 32'h0badf00d, 1'b1, 32'h0badf00d);
        // margins overlap on a 16 x 16 screen
        add_cfg(REG_SCREEN_WIDTH, 32'd16);
        add_cfg(REG_SCREEN_HEIGHT, 32'd16);
        add_cfg(REG_GRADIENT_SIZE, 32'd3);
        add_pix(16'd8, 16'd8, 32'hffffffff, 1'b0, 32'h0);
        add_pix(16'd12, 16'd8, 32'hcafe1234, 1'b1, 32'hcafe1234);
        // no backdrop: base colour passes whole
        add_cfg(REG_BASE_COLOUR, 32'ha1b2c3d4);
        add_cfg(REG_BACKDROP, 32'd0);
        add_pix(16'd20, 16'd20, 32'h00000000, 1'b1, 32'ha1b2c3d4);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                drain_canvas();
                write_reg(rows[i].addr, rows[i].value);
            end else begin
                offer_pixel(rows[i].x, rows[i].y, rows[i].backdrop, rows[i].has_want,
                            rows[i].want);
            end
        end

        for (int p = 0; p < NumPhases; p++) begin
            drain_canvas();
            case (p)
                0: apply_setting(1024, 768, 64, 4, 32'h40ff8000, 1'b1);
                1: apply_setting(320, 200, 40, 40, 32'hff112233, 1'b1);
                2: apply_setting(200, 150, 30, 17, 32'h00abcdef, 1'b1);
                3: apply_setting(65535, 65535, 4095, 4095, 32'hffffffff, 1'b1);
                4: apply_setting(1, 1, 0, 0, 32'h00000000, 1'b1);
                5: apply_setting(100, 60, 40, 4095, $urandom, 1'b1);
                6: apply_setting(640, 480, 50, 0, $urandom, 1'b1);
                7: apply_setting(800, 600, 32, 8, 32'ha5c33c5a, 1'b0);
                default: begin
                    rm = $urandom_range(0, 300);
                    apply_setting($urandom_range(1, 3000), $urandom_range(1, 3000), rm,
                                  $urandom_range(0, rm + 5), $urandom, 1'b1);
                end
            endcase
            tx_idle_en = (p < NumPhases - 1);
            rx_idle_en = (p < NumPhases - 1);
            for (int i = 0; i < PhaseItems; i++) begin
                if (p == 1 && i == 30)
                    hold_req = 1'b1;
                if (p == 2 && i == 50)
                    drain_canvas();
                offer_pixel(pick_coord(cur_width), pick_coord(cur_height), $urandom, 1'b0,
                            32'h0);
            end
        end

        drain_canvas();
        $display("%0d pixel transactions over %0d register settings; %0d canvas results compared",
                 pixels_sent, settings_used, canvas_checked);
        $display("%0d mismatches", errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
